// ===== design/crc_pkg.sv =====
// Shared types and constants for the coin ratio classifier.
// Used by crc_front, crc_back and coin_ratio_classifier; no dependencies.
package crc_pkg;

    // Fixed sizes
    localparam int COIN_KINDS  = 8;
    localparam int COIN_IDX_W  = 3;
    localparam int CAL_COIN_W  = 4;
    localparam int TS_W        = 32;
    localparam int RATIO_W     = 16;
    localparam int CENTS_W     = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int PROBE_COUNT = 7;
    localparam int DIV_CNT_W   = 5;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CALIBRATE_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CAL_COIN       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAYMENT_TARGET = 2'd2;

    // Configuration reset values
    localparam logic [CAL_COIN_W-1:0] CAL_COIN_NONE  = 4'd8;
    localparam logic [CENTS_W-1:0]    TARGET_DEFAULT = 8'd120;

    // Operation codes
    localparam logic OP_PASSAGE      = 1'b0;
    localparam logic OP_WINDOW_RESET = 1'b1;

    // Ratio constants
    localparam logic [RATIO_W-1:0] RATIO_NONE       = 16'hFFFF;
    localparam logic [RATIO_W-1:0] WINDOW_RESET_LOW = 16'd100;
    localparam logic [RATIO_W-1:0] WINDOW_RESET_HIGH = 16'd0;

    // Window defaults, per coin kind 1c..200c
    localparam logic [RATIO_W-1:0] LOW_INIT [COIN_KINDS] =
        '{16'd1000, 16'd438, 16'd250, 16'd328, 16'd216, 16'd175, 16'd190, 16'd155};
    localparam logic [RATIO_W-1:0] HIGH_INIT [COIN_KINDS] =
        '{16'd0, 16'd514, 16'd270, 16'd376, 16'd230, 16'd185, 16'd205, 16'd162};

    // Window probe order: 5c, 2c, 200c, 100c, 50c, 20c, 10c
    localparam logic [COIN_IDX_W-1:0] PROBE_ORDER [PROBE_COUNT] =
        '{3'd2, 3'd1, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3};

    localparam logic [CENTS_W-1:0] KIND_CENTS [COIN_KINDS] =
        '{8'd1, 8'd2, 8'd5, 8'd10, 8'd20, 8'd50, 8'd100, 8'd200};

    // Window indexes used by the gate pre-check
    localparam logic [COIN_IDX_W-1:0] GATE_HIGH_KIND = 3'd3;
    localparam logic [COIN_IDX_W-1:0] GATE_LOW_KIND  = 3'd5;

    // Accepted value range and the 5c value
    localparam logic [CENTS_W-1:0] CENTS_MIN_ACCEPT = 8'd10;
    localparam logic [CENTS_W-1:0] CENTS_MAX_ACCEPT = 8'd100;
    localparam logic [CENTS_W-1:0] CENTS_FIVE       = 8'd5;

    // Prepared command: scaled difference and divisor
    typedef struct packed {
        logic            op;
        logic [TS_W-1:0] d100;
        logic [TS_W-1:0] s;
    } cmd_t;

    typedef struct packed {
        logic                  calibrate_mode;
        logic [CAL_COIN_W-1:0] cal_coin;
        logic [CENTS_W-1:0]    payment_target;
    } cfg_t;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [CENTS_W-1:0] coin_cents;
        logic               accepted;
        logic               open_gate;
        logic [CENTS_W-1:0] payment_total;
        logic               payment_done;
    } result_t;

endpackage

// ===== design/crc_front.sv =====
// Front end: takes timestamp items, forms d*100 and s, queues commands.
// Depends on crc_pkg.
module crc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   operation,
    input  logic [crc_pkg::TS_W-1:0] t_first_entry,
    input  logic [crc_pkg::TS_W-1:0] t_second_entry,
    input  logic [crc_pkg::TS_W-1:0] t_first_exit,
    output logic                   cmd_valid,
    input  logic                   cmd_take,
    output crc_pkg::cmd_t          cmd
);

    crc_pkg::cmd_t                      queue_reg [crc_pkg::QUEUE_DEPTH];
    logic [crc_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [crc_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [crc_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [crc_pkg::QUEUE_CNT_W-1:0]    count_next;
    logic [crc_pkg::TS_W-1:0]           d;
    crc_pkg::cmd_t                      entry;
    logic                               wr_en;
    logic                               rd_en;

    // Form the wrapped differences; d*100 as shift-and-add
    always_comb
    begin
        d          = t_second_entry - t_first_entry;
        entry.op   = operation;
        entry.s    = t_first_exit - t_second_entry;
        entry.d100 = (d << 6) + (d << 5) + (d << 2);
    end

    assign full      = (count_reg == crc_pkg::QUEUE_CNT_W'(crc_pkg::QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_take && cmd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store the prepared command
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

    // Count never passes the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= crc_pkg::QUEUE_CNT_W'(crc_pkg::QUEUE_DEPTH))
        else $error("command queue count overflow");

    // A full queue with no read stays full
    assert property (@(posedge clk) disable iff (!rst_n)
        full && !cmd_take |=> full)
        else $error("command queue lost an entry while full");

endmodule

// ===== design/crc_back.sv =====
// Back end: serial divider, window match, calibration and payment total.
// Holds the window tables and the result register. Depends on crc_pkg.
module crc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  crc_pkg::cfg_t       cfg,
    input  logic                cmd_valid,
    output logic                cmd_take,
    input  crc_pkg::cmd_t       cmd,
    output logic                empty,
    input  logic                pop,
    output crc_pkg::result_t    res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]                          state_reg;
    logic                                op_reg;
    logic [crc_pkg::TS_W-1:0]            quot_reg;
    logic [crc_pkg::TS_W-1:0]            rem_reg;
    logic [crc_pkg::TS_W-1:0]            div_reg;
    logic [crc_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic [crc_pkg::RATIO_W-1:0]         win_low_reg  [crc_pkg::COIN_KINDS];
    logic [crc_pkg::RATIO_W-1:0]         win_high_reg [crc_pkg::COIN_KINDS];
    logic [crc_pkg::CENTS_W-1:0]         paid_reg;
    logic [crc_pkg::CENTS_W-1:0]         paid_next;
    crc_pkg::result_t                    res_reg;
    crc_pkg::result_t                    res_next;
    logic                                res_valid_reg;

    logic [crc_pkg::TS_W:0]              trial;
    logic [crc_pkg::TS_W:0]              shifted;
    logic [crc_pkg::RATIO_W-1:0]         ratio;
    logic [crc_pkg::COIN_IDX_W-1:0]      cal_idx;
    logic                                cal_sel;
    logic [crc_pkg::COIN_IDX_W-1:0]      kind;
    logic [crc_pkg::CENTS_W-1:0]         cents;
    logic [crc_pkg::CENTS_W:0]           sum;
    logic                                slot_free;
    logic                                apply;

    assign cmd_take  = (state_reg == ST_IDLE) && cmd_valid;
    assign slot_free = !res_valid_reg || pop;
    assign apply     = (state_reg == ST_APPLY) && slot_free;
    assign empty     = !res_valid_reg;
    assign res       = res_reg;
    assign ratio     = quot_reg[crc_pkg::RATIO_W-1:0];
    assign cal_idx   = cfg.cal_coin[crc_pkg::COIN_IDX_W-1:0];
    assign cal_sel   = !cfg.cal_coin[crc_pkg::CAL_COIN_W-1];

    // One restoring division step
    always_comb
    begin
        shifted = {rem_reg, quot_reg[crc_pkg::TS_W-1]};
        trial   = shifted - {1'b0, div_reg};
    end

    // Match windows; the earliest entry in probe order wins, else 1c
    always_comb
    begin
        kind = '0;
        for (int i = crc_pkg::PROBE_COUNT - 1; i >= 0; i--)
        begin
            if (ratio >= win_low_reg[crc_pkg::PROBE_ORDER[i]] &&
                ratio <= win_high_reg[crc_pkg::PROBE_ORDER[i]])
            begin
                kind = crc_pkg::PROBE_ORDER[i];
            end
        end
        cents = crc_pkg::KIND_CENTS[kind];
        sum   = {1'b0, paid_reg} + {1'b0, cents};
    end

    // Build the result and the next payment total
    always_comb
    begin
        res_next               = '0;
        paid_next              = paid_reg;
        if (op_reg == crc_pkg::OP_PASSAGE && !cfg.calibrate_mode)
        begin
            res_next.coin_cents = cents;
            if (ratio >= win_high_reg[crc_pkg::GATE_HIGH_KIND] ||
                ratio <= win_low_reg[crc_pkg::GATE_LOW_KIND] ||
                cents == crc_pkg::CENTS_FIVE)
            begin
                res_next.open_gate = 1'b1;
            end
            if (cents < crc_pkg::CENTS_MIN_ACCEPT || cents > crc_pkg::CENTS_MAX_ACCEPT)
            begin
                res_next.open_gate = 1'b1;
            end
            else
            begin
                res_next.accepted = 1'b1;
                if (sum >= {1'b0, cfg.payment_target})
                begin
                    res_next.payment_done = 1'b1;
                    paid_next             = '0;
                end
                else
                begin
                    paid_next = sum[crc_pkg::CENTS_W-1:0];
                end
            end
        end
        res_next.ratio         = ratio;
        res_next.payment_total = paid_next;
    end

    // Sequence: take command, divide (skipped for a window reset or a zero s), apply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            paid_reg      <= '0;
            for (int k = 0; k < crc_pkg::COIN_KINDS; k++)
            begin
                win_low_reg[k]  <= crc_pkg::LOW_INIT[k];
                win_high_reg[k] <= crc_pkg::HIGH_INIT[k];
            end
        end
        else
        begin
            // Drop the result once transferred, unless a new one replaces it
            if (pop && res_valid_reg && !apply)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cnt_reg <= '0;
                        if (cmd.op == crc_pkg::OP_WINDOW_RESET || cmd.s == '0)
                        begin
                            state_reg <= ST_APPLY;
                        end
                        else
                        begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == '1)
                    begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY:
                begin
                    if (slot_free)
                    begin
                        state_reg     <= ST_IDLE;
                        res_valid_reg <= 1'b1;
                        paid_reg      <= paid_next;
                        if (cal_sel)
                        begin
                            if (op_reg == crc_pkg::OP_WINDOW_RESET)
                            begin
                                win_low_reg[cal_idx]  <= crc_pkg::WINDOW_RESET_LOW;
                                win_high_reg[cal_idx] <= crc_pkg::WINDOW_RESET_HIGH;
                            end
                            else if (cfg.calibrate_mode)
                            begin
                                if (win_low_reg[cal_idx] > ratio)
                                begin
                                    win_low_reg[cal_idx] <= ratio;
                                end
                                if (win_high_reg[cal_idx] < ratio)
                                begin
                                    win_high_reg[cal_idx] <= ratio;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Divider datapath and result payload
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            op_reg  <= cmd.op;
            div_reg <= cmd.s;
            rem_reg <= '0;
            if (cmd.op == crc_pkg::OP_WINDOW_RESET)
            begin
                quot_reg <= '0;
            end
            else if (cmd.s == '0)
            begin
                quot_reg <= crc_pkg::TS_W'(crc_pkg::RATIO_NONE);
            end
            else
            begin
                quot_reg <= cmd.d100;
            end
        end
        else if (state_reg == ST_DIV)
        begin
            if (!trial[crc_pkg::TS_W])
            begin
                rem_reg  <= trial[crc_pkg::TS_W-1:0];
                quot_reg <= {quot_reg[crc_pkg::TS_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[crc_pkg::TS_W-1:0];
                quot_reg <= {quot_reg[crc_pkg::TS_W-2:0], 1'b0};
            end
        end
        if (apply)
        begin
            res_reg <= res_next;
        end
    end

    // A waiting result is not overwritten before it is transferred
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !pop |=> res_valid_reg && $stable(res_reg))
        else $error("waiting result changed before transfer");

    // Commands are only taken while idle, and taking one always starts work
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> state_reg == ST_DIV || state_reg == ST_APPLY)
        else $error("command taken without starting work");

    // Division always runs its full count before applying
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && cnt_reg != '1 |=> state_reg == ST_DIV)
        else $error("division left early");

endmodule

// ===== design/coin_ratio_classifier.sv =====
// Coin ratio classifier top level: configuration registers, front and back.
// Depends on crc_pkg, crc_front and crc_back.
//
// Each coin passage gives three timestamps; the block forms the ratio
// (d*100)/s and classifies, calibrates or resets a window. Items enter through
// a two-entry command queue, so up to two items can be pushed while the back
// end works and a finished result waits to be popped. A coin passage with a
// non-zero s takes the command, runs 32 steps of the bit-serial restoring divider,
// then updates the windows and the total once the result slot is free; a window
// reset or a zero s skips the divider. No new command is taken until the last item
// is applied. Configuration writes take effect at once and should be made idle.
module coin_ratio_classifier (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [crc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [crc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input side
    input  logic                                push,
    output logic                                full,
    input  logic                                operation,
    input  logic [crc_pkg::TS_W-1:0]            t_first_entry,
    input  logic [crc_pkg::TS_W-1:0]            t_second_entry,
    input  logic [crc_pkg::TS_W-1:0]            t_first_exit,
    // result side
    output logic                                empty,
    input  logic                                pop,
    output logic [crc_pkg::RATIO_W-1:0]         ratio,
    output logic [crc_pkg::CENTS_W-1:0]         coin_cents,
    output logic                                accepted,
    output logic                                open_gate,
    output logic [crc_pkg::CENTS_W-1:0]         payment_total,
    output logic                                payment_done
);

    crc_pkg::cfg_t      cfg_reg;
    crc_pkg::cmd_t      cmd;
    crc_pkg::result_t   res;
    logic               cmd_valid;
    logic               cmd_take;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.calibrate_mode <= 1'b0;
            cfg_reg.cal_coin       <= crc_pkg::CAL_COIN_NONE;
            cfg_reg.payment_target <= crc_pkg::TARGET_DEFAULT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crc_pkg::REG_CALIBRATE_MODE:
                begin
                    cfg_reg.calibrate_mode <= cfg_data[0];
                end
                crc_pkg::REG_CAL_COIN:
                begin
                    cfg_reg.cal_coin <= cfg_data[crc_pkg::CAL_COIN_W-1:0];
                end
                crc_pkg::REG_PAYMENT_TARGET:
                begin
                    cfg_reg.payment_target <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    crc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .operation      (operation),
        .t_first_entry  (t_first_entry),
        .t_second_entry (t_second_entry),
        .t_first_exit   (t_first_exit),
        .cmd_valid      (cmd_valid),
        .cmd_take       (cmd_take),
        .cmd            (cmd)
    );

    crc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign ratio         = res.ratio;
    assign coin_cents    = res.coin_cents;
    assign accepted      = res.accepted;
    assign open_gate     = res.open_gate;
    assign payment_total = res.payment_total;
    assign payment_done  = res.payment_done;

endmodule
